@@ rtl/stereo_audio_fifo_with_underrun_silence_top_assert.svh @@
// Assertion macros for the stereo audio FIFO.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STEREO_AUDIO_FIFO_WITH_UNDERRUN_SILENCE_TOP_ASSERT_SVH
`define STEREO_AUDIO_FIFO_WITH_UNDERRUN_SILENCE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saf check failed");
`define SAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saf check failed");
`else
`define SAF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SAF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/saf_pkg.sv @@
// Shared constants and types of the stereo audio FIFO.
// No dependencies; imported by the frame RAM, the top level and the test files.
`timescale 1ns / 1ps
`default_nettype none
package saf_pkg;
    localparam int MAX_FRAMES  = 1024;
    localparam int ADDR_W      = $clog2(MAX_FRAMES);
    localparam int POS_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 32;
    localparam int WORD_W      = 32;
    localparam int FRAME_W     = 2 * WORD_W;
    localparam int CNT_W       = 11;
    localparam int CAPLOG_W    = 4;
    localparam int OUT_DATA_W  = 152;

    localparam logic [WORD_W-1:0] SAMPLE_MASK =
        WORD_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [CAPLOG_W-1:0] CAPLOG_RESET = CAPLOG_W'(ADDR_W);

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic              we;
        addr_t             waddr;
        frame_t            wdata;
        logic              re;
        addr_t             raddr;
    } ram_req_t;
endpackage
`default_nettype wire

@@ rtl/stereo_audio_fifo_with_underrun_silence_top.sv @@
// Top level of the stereo audio FIFO with underrun silence.
// Depends on saf_pkg, saf_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_audio_fifo_with_underrun_silence_top_assert.svh"
// One beat in, one beat out: a write beat stores a stereo frame (or drops it
// when full, counting an overflow), a read beat returns the oldest frame (or
// zero silence when empty, counting an underflow). The block takes one beat
// per cycle while s_tready is high; each result passes through the pending
// stage, which waits for the registered read of the frame RAM, and then the
// output register before it is offered on m_tvalid.
// Positions and totals live in flip-flops and update at acceptance, so a read
// of a frame written on the previous beat sees it without forwarding. Input
// ready drops only when both the pending stage and the output register are
// full and the output is stalled. Writing capacity_log2 (only while idle)
// empties the FIFO and clears all counters; values above ten use 1024 frames.
// The frame RAM needs no clearing pass: an entry is never read before it is
// written.
module stereo_audio_fifo_with_underrun_silence_top
    import saf_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire [CAPLOG_W-1:0]     cfg_wdata,   // capacity_log2
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire [FRAME_W-1:0]      s_tdata,     // left_in[31:0], right_in[63:32]
    input  wire                    s_tuser,     // kind
    input  wire                    s_tlast,     // block_end
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,     // left_out[31:0], right_out[63:32],
                                                // frames_available[74:64],
                                                // overflow_count[106:75],
                                                // underflow_count[138:107],
                                                // block_count[149:139], zero pad
    output logic                   m_tuser      // accepted
);
    // Control state
    logic [CAPLOG_W-1:0] caplog_reg;
    pos_t                wp_reg, wp_next;
    pos_t                rp_reg, rp_next;
    logic [WORD_W-1:0]   ovf_reg, ovf_next;
    logic [WORD_W-1:0]   unf_reg, unf_next;
    logic [CNT_W-1:0]    call_reg, call_next;

    // Pending stage: waits for the registered RAM read word
    logic                pend_valid_reg;
    logic                pend_acc_reg;
    logic                pend_real_reg;
    logic [CNT_W-1:0]    pend_avail_reg;
    logic [WORD_W-1:0]   pend_ovf_reg;
    logic [WORD_W-1:0]   pend_unf_reg;
    logic [CNT_W-1:0]    pend_blk_reg;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_acc_reg;

    logic                in_fire;
    logic                pend_adv;
    kind_t               kind;
    pos_t                cap;
    addr_t               slot_mask;
    pos_t                avail;
    logic                full;
    logic                empty;
    logic                acc;
    logic [CNT_W-1:0]    cnt_sum;
    logic [CNT_W-1:0]    blk;
    ram_req_t            ram_req;
    frame_t              ram_rdata;
    logic [WORD_W-1:0]   left_sel, right_sel;

    assign kind     = kind_t'(s_tuser);
    assign pend_adv = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_valid_reg || !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Saturate the capacity at the RAM depth.
    always_comb
    begin
        if (caplog_reg > CAPLOG_W'(ADDR_W))
        begin
            cap = pos_t'(MAX_FRAMES);
        end
        else
        begin
            cap = pos_t'(1) << caplog_reg;
        end
    end

    assign slot_mask = addr_t'(cap - pos_t'(1));
    assign avail     = wp_reg - rp_reg;
    assign full      = (avail >= cap);
    assign empty     = (avail == '0);

    // Next state of positions and counters for the beat being accepted.
    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        ovf_next = ovf_reg;
        unf_next = unf_reg;
        acc = 1'b0;
        case (kind)
            KIND_WRITE:
            begin
                if (!full)
                begin
                    wp_next = wp_reg + pos_t'(1);
                    acc = 1'b1;
                end
                else
                begin
                    ovf_next = ovf_reg + WORD_W'(1);
                end
            end
            KIND_READ:
            begin
                if (!empty)
                begin
                    rp_next = rp_reg + pos_t'(1);
                    acc = 1'b1;
                end
                else
                begin
                    unf_next = unf_reg + WORD_W'(1);
                end
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
        cnt_sum   = call_reg + CNT_W'(acc);
        blk       = s_tlast ? cnt_sum : '0;
        call_next = s_tlast ? '0 : cnt_sum;
    end

    // RAM request: store on an accepted write, fetch on a real read.
    always_comb
    begin
        ram_req.we    = in_fire && (kind == KIND_WRITE) && !full;
        ram_req.waddr = wp_reg[ADDR_W-1:0] & slot_mask;
        ram_req.wdata = {s_tdata[FRAME_W-1:WORD_W] & SAMPLE_MASK,
                         s_tdata[WORD_W-1:0] & SAMPLE_MASK};
        ram_req.re    = in_fire && (kind == KIND_READ) && !empty;
        ram_req.raddr = rp_reg[ADDR_W-1:0] & slot_mask;
    end

    saf_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caplog_reg <= CAPLOG_RESET;
            wp_reg     <= '0;
            rp_reg     <= '0;
            ovf_reg    <= '0;
            unf_reg    <= '0;
            call_reg   <= '0;
        end
        else if (cfg_we)
        begin
            // Re-initialise the FIFO on a capacity change.
            caplog_reg <= cfg_wdata;
            wp_reg     <= '0;
            rp_reg     <= '0;
            ovf_reg    <= '0;
            unf_reg    <= '0;
            call_reg   <= '0;
        end
        else if (in_fire)
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            ovf_reg  <= ovf_next;
            unf_reg  <= unf_next;
            call_reg <= call_next;
        end
    end

    // Pending stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    // Pending stage payload: capture the result fields at acceptance.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_acc_reg   <= acc;
            pend_real_reg  <= (kind == KIND_READ) && !empty;
            pend_avail_reg <= CNT_W'(wp_next - rp_next);
            pend_ovf_reg   <= ovf_next;
            pend_unf_reg   <= unf_next;
            pend_blk_reg   <= blk;
        end
    end

    // Zero the sample words on writes and on silence.
    assign left_sel  = pend_real_reg ? ram_rdata[WORD_W-1:0] : '0;
    assign right_sel = pend_real_reg ? ram_rdata[FRAME_W-1:WORD_W] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_adv)
        begin
            out_acc_reg  <= pend_acc_reg;
            out_data_reg <= {2'b00, pend_blk_reg, pend_unf_reg, pend_ovf_reg,
                             pend_avail_reg, right_sel, left_sel};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_acc_reg;

    // Checks
    `SAF_ASSERT_SAME(a_held_within_cap, clk, rst_n, 1'b1, avail <= cap)
    `SAF_ASSERT_SAME(a_ready_only_when_full, clk, rst_n, !s_tready,
                     pend_valid_reg && out_valid_reg)
    `SAF_ASSERT_NEXT(a_rdata_held_in_stall, clk, rst_n,
                     pend_valid_reg && out_valid_reg && !m_tready,
                     ram_rdata === $past(ram_rdata))
    `SAF_ASSERT_NEXT(a_write_advances, clk, rst_n,
                     in_fire && !cfg_we && (kind == KIND_WRITE) && !full,
                     wp_reg == $past(wp_reg) + pos_t'(1))
endmodule
`default_nettype wire

@@ rtl/saf_ram.sv @@
// Frame store: one write port and one registered read port, 64-bit frames.
// Depends on saf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module saf_ram
    import saf_pkg::*;
(
    input  wire           clk,
    input  wire ram_req_t req,
    output frame_t        rdata
);
    frame_t mem [MAX_FRAMES];
    frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Hold the read word until the next read request.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ test/saf_frame_checker.sv @@
// Result checker for the stereo audio FIFO: mirrors the frame store, positions and totals.
// Depends on saf_pkg; instantiated next to the block by the testbench top.
`timescale 1ns / 1ps
module saf_frame_checker
    import saf_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire [CAPLOG_W-1:0]     cfg_wdata,
    input  wire                    s_tvalid,
    input  wire                    s_tready,
    input  wire [FRAME_W-1:0]      s_tdata,
    input  wire                    s_tuser,
    input  wire                    s_tlast,
    input  wire                    m_tvalid,
    input  wire                    m_tready,
    input  wire [OUT_DATA_W-1:0]   m_tdata,
    input  wire                    m_tuser,
    output int                     replies_owed,
    output int                     mismatch_count
);
    typedef struct packed
    {
        logic              accepted;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [CNT_W-1:0]  avail;
        logic [31:0]       overflows;
        logic [31:0]       underflows;
        logic [CNT_W-1:0]  call_frames;
    } fifo_reply_t;

    frame_t              frame_mem [MAX_FRAMES];
    pos_t                wr_pos = '0;
    pos_t                rd_pos = '0;
    logic [31:0]         dropped = '0;
    logic [31:0]         silenced = '0;
    logic [CNT_W-1:0]    call_frames = '0;
    logic [CAPLOG_W-1:0] cap_log2 = CAPLOG_RESET;
    fifo_reply_t         pending_replies [$];

    initial
    begin
        replies_owed   = 0;
        mismatch_count = 0;
    end

    task automatic clear_positions();
        wr_pos      = '0;
        rd_pos      = '0;
        dropped     = '0;
        silenced    = '0;
        call_frames = '0;
    endtask

    // Advance the mirrored FIFO by one beat and return the reply it must produce.
    function automatic fifo_reply_t fifo_beat(kind_t kind, frame_t frame, logic last);
        fifo_reply_t rep;
        pos_t        cap;
        pos_t        held;
        addr_t       slot_mask;
        frame_t      word;
        rep       = '0;
        cap       = (cap_log2 > ADDR_W) ? pos_t'(MAX_FRAMES) : pos_t'(1) << cap_log2;
        slot_mask = addr_t'(cap - pos_t'(1));
        held      = wr_pos - rd_pos;
        if (kind == KIND_WRITE)
        begin
            if (held < cap)
            begin
                frame_mem[addr_t'(wr_pos) & slot_mask] = frame;
                wr_pos = wr_pos + pos_t'(1);
                rep.accepted = 1'b1;
            end
            else
                dropped = dropped + 32'd1;
        end
        else
        begin
            if (held != '0)
            begin
                word = frame_mem[addr_t'(rd_pos) & slot_mask];
                rep.left  = word[WORD_W-1:0];
                rep.right = word[FRAME_W-1:WORD_W];
                rd_pos = rd_pos + pos_t'(1);
                rep.accepted = 1'b1;
            end
            else
                silenced = silenced + 32'd1;
        end
        call_frames = call_frames + CNT_W'(rep.accepted);
        if (last)
        begin
            rep.call_frames = call_frames;
            call_frames     = '0;
        end
        rep.avail      = CNT_W'(wr_pos - rd_pos);
        rep.overflows  = dropped;
        rep.underflows = silenced;
        return rep;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        fifo_reply_t seen;
        fifo_reply_t want;
        if (!rst_n)
        begin
            cap_log2 = CAPLOG_RESET;
            clear_positions();
            pending_replies.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                cap_log2 = cfg_wdata;
                clear_positions();
            end
            if (m_tvalid && m_tready)
            begin
                seen.accepted    = m_tuser;
                seen.left        = m_tdata[31:0];
                seen.right       = m_tdata[63:32];
                seen.avail       = m_tdata[74:64];
                seen.overflows   = m_tdata[106:75];
                seen.underflows  = m_tdata[138:107];
                seen.call_frames = m_tdata[149:139];
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: reply beat expected none actual %0h", $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(seen.accepted));
                    check_field("left_out", want.left, seen.left);
                    check_field("right_out", want.right, seen.right);
                    check_field("frames_available", 32'(want.avail), 32'(seen.avail));
                    check_field("overflow_count", want.overflows, seen.overflows);
                    check_field("underflow_count", want.underflows, seen.underflows);
                    check_field("block_count", 32'(want.call_frames),
                                32'(seen.call_frames));
                end
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(fifo_beat(kind_t'(s_tuser), s_tdata, s_tlast));
        end
        replies_owed = pending_replies.size();
    end
endmodule

@@ test/tb_stereo_audio_fifo_with_underrun_silence_top.sv @@
// Testbench top for the stereo audio FIFO: clock, reset, stimulus, flow control and verdict.
// Depends on saf_pkg, the block itself and saf_frame_checker.
`timescale 1ns / 1ps
module tb_stereo_audio_fifo_with_underrun_silence_top;
    import saf_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 300;   // long output hold-off
    localparam int PHASE_BEATS  = 60;
    localparam int FILL_BEATS   = 40;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CAPLOG_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [FRAME_W-1:0]    s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tuser;

    int replies_owed;
    int mismatch_count;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int holds_served = 0;

    // Ten random phases; each one starts with a fresh capacity, extremes included.
    int phase_caps [10] = '{2, 1, 3, 11, 4, 0, 5, 10, 6, 2};

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    stereo_audio_fifo_with_underrun_silence_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    saf_frame_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .replies_owed   (replies_owed),
        .mismatch_count (mismatch_count)
    );

    // Set how often the sender idles and the receiver stalls, in percent of cycles.
    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin idle_pct = 82; stall_pct = 0;  end
            IDLE_RECV: begin idle_pct = 0;  stall_pct = 82; end
            default:   begin idle_pct = 9;  stall_pct = 9;  end
        endcase
    endtask

    // Offer one beat and hold it until the block takes it. Called at a rising edge;
    // returns at the edge that accepted the beat, leaving tvalid high for the next one.
    task automatic send_beat(kind_t kind, logic [WORD_W-1:0] left, logic [WORD_W-1:0] right,
                             logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= kind;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop tvalid and wait until every reply owed has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed != 0);
    endtask

    // Write capacity_log2; the block is idle whenever this is called.
    task automatic write_capacity(logic [CAPLOG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sample words biased towards the all-zero and all-one patterns.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Output side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_served != hold_reqs)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_stereo_audio_fifo_with_underrun_silence_top: errors");
        $finish;
    end

    initial
    begin : stimulus
        int          i;
        int          p;
        int          write_bias;
        kind_t       kind;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity of 1024 frames.
        set_idling(IDLE_NONE);
        send_beat(KIND_READ, '0, '0, 1'b0);                    // silence on empty
        send_beat(KIND_READ, '1, '1, 1'b1);                    // call with nothing taken
        send_beat(KIND_WRITE, '0, '0, 1'b0);
        send_beat(KIND_WRITE, '1, '1, 1'b0);
        send_beat(KIND_WRITE, 32'haaaa_aaaa, 32'h5555_5555, 1'b1);
        send_beat(KIND_READ, '0, '0, 1'b0);
        send_beat(KIND_READ, '0, '0, 1'b0);
        send_beat(KIND_READ, '0, '0, 1'b1);
        send_beat(KIND_READ, '0, '0, 1'b0);
        drain();

        // Single-frame FIFO: store, drop on full, read back, silence, then leave a frame.
        write_capacity(4'd0);
        send_beat(KIND_WRITE, 32'h1234_5678, 32'h9abc_def0, 1'b0);
        send_beat(KIND_WRITE, 32'hdead_beef, 32'hcafe_f00d, 1'b0);
        send_beat(KIND_READ, '0, '0, 1'b0);
        send_beat(KIND_READ, '0, '0, 1'b0);
        send_beat(KIND_WRITE, 32'h5555_5555, 32'haaaa_aaaa, 1'b1);
        drain();

        // An oversized capacity saturates to the full store; the write also empties
        // the FIFO, so the first read must be silence. Then store a run of frames
        // larger than any small capacity and read two past empty in one call.
        write_capacity(4'd15);
        send_beat(KIND_READ, '0, '0, 1'b1);
        for (i = 0; i < FILL_BEATS; i++)
            send_beat(KIND_WRITE, $urandom, $urandom, 1'b0);
        for (i = 0; i < FILL_BEATS + 2; i++)
            send_beat(KIND_READ, $urandom, $urandom, 1'b0);
        send_beat(KIND_WRITE, '1, '0, 1'b1);
        drain();

        // Random phases: write-heavy and read-heavy stretches alternate so that
        // small capacities hit both full and empty.
        for (p = 0; p < 10; p++)
        begin
            write_capacity(CAPLOG_W'(phase_caps[p]));
            set_idling(idle_mode_t'(p % 4));
            for (i = 0; i < PHASE_BEATS; i++)
            begin
                if (p == 4 && i == 20)
                    hold_reqs++;                   // hold the output while input keeps coming
                if (p == 5 && i == 35)
                    drain();                       // pause input until every reply is back
                write_bias = ((i / 12) % 2 == 0) ? 75 : 25;
                kind = ($urandom_range(0, 99) < write_bias) ? KIND_WRITE : KIND_READ;
                send_beat(kind, pick_word(), pick_word(), $urandom_range(0, 7) == 0);
            end
            drain();
        end

        // Let the pipeline settle, then give the verdict.
        stall_pct = 0;
        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_stereo_audio_fifo_with_underrun_silence_top: clean");
        else
            $display("tb_stereo_audio_fifo_with_underrun_silence_top: errors");
        $finish;
    end
endmodule
